>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mpa_pkg.sv
package mpa_pkg;

    // field widths
    localparam int ADC_W    = 12;
    localparam int AVG_W    = 14;
    localparam int CNT_W    = 16;
    localparam int SUM_W    = 28;

    // default full-scale reading
    localparam int ADC_FULL_SCALE_DEF = 4095;

    // percent scaling, 10000 hundredths and twice that for half-up rounding
    localparam int PCT_SCALE = 10000;
    localparam int PCT_X2    = 20000;
    localparam int PCT_X2_W  = 15;

    // dividend width: sum * 20000 plus the denominator
    localparam int NUM_W    = 44;

    // register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_IDX = 1'b0;
    localparam logic [CNT_W-1:0]     PERIOD_RESET   = 16'd10;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DEN,
        ST_MUL_NUM,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

>>> hw/rtl/mpa_sample_if.sv
interface mpa_sample_if;

    logic                       valid;
    logic                       ready;
    logic [mpa_pkg::ADC_W-1:0]  adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);

endinterface

>>> hw/rtl/mpa_result_if.sv
interface mpa_result_if;

    logic                       valid;
    logic                       ready;
    logic [mpa_pkg::AVG_W-1:0]  avg_moisture_hundredths;
    logic [mpa_pkg::CNT_W-1:0]  samples_in_period;

    modport source (output valid, output avg_moisture_hundredths,
                    output samples_in_period, input ready);
    modport sink   (input valid, input avg_moisture_hundredths,
                    input samples_in_period, output ready);

endinterface

>>> hw/rtl/moisture_period_averager.sv
// moisture period averager
// i_sample (valid/ready) takes one 12-bit raw soil reading per transaction;
// higher readings mean drier soil. the inverted reading is summed and counted
// until the count reaches the period register (APB, byte address 0, reset 10).
// o_result (valid/ready) then carries the period average in hundredths of a
// percent, rounded half up, with the number of samples in the period.
// a sample that does not close a period leaves ready high, so such samples
// may arrive back to back.
// a sample that closes a period starts a sequence on one shared multiplier
// (two products), one add, then a 44-step restoring divider, one quotient
// bit per cycle, one step per dividend bit; when the result is offered,
// i_sample is ready again from that same cycle.
// the result sits in an output register; if the receiver stalls, a later
// period can run its divide and then waits until that register is free.
// reset (synchronous, active low) clears the sum, the count and any pending
// result, and sets the period to 10.
`include "assert_macros.svh"

module moisture_period_averager #(
    parameter int ADC_FULL_SCALE = mpa_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    mpa_sample_if.sink                         i_sample,
    mpa_result_if.source                       o_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mpa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mpa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mpa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    import mpa_pkg::*;

    // derived widths
    localparam int FW     = $clog2(ADC_FULL_SCALE + 1);
    localparam int CW     = (FW > ADC_W) ? FW : ADC_W;
    localparam int MB_W   = (FW > PCT_X2_W) ? FW : PCT_X2_W;
    localparam int PROD_W = SUM_W + MB_W;
    localparam int DEN_W  = FW + CNT_W;
    localparam int STEP_W = $clog2(NUM_W);

    localparam logic [CW-1:0]     FULL_C    = CW'(ADC_FULL_SCALE);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);
    localparam logic [AVG_W-1:0]  AVG_MAX   = AVG_W'(PCT_SCALE);

    t_state                r_state;
    t_state                n_state;

    logic [CNT_W-1:0]      r_period;
    logic [SUM_W-1:0]      r_sum;
    logic [CNT_W-1:0]      r_count;
    logic [DEN_W-1:0]      r_den;
    logic [NUM_W-1:0]      r_num;
    logic [DEN_W:0]        r_rem;
    logic [AVG_W-1:0]      r_quot;
    logic                  r_ovf;
    logic [STEP_W-1:0]     r_step;
    logic                  r_out_valid;
    logic [AVG_W-1:0]      r_avg;
    logic [CNT_W-1:0]      r_spp;

    logic                  in_ready;
    logic                  in_fire;
    logic                  mul_num_sel;
    logic                  load_out;
    logic                  cfg_wr;

    logic [CW-1:0]         raw_ext;
    logic [FW-1:0]         inv;
    logic [SUM_W:0]        sum_add;
    logic [SUM_W-1:0]      acc_sum;
    logic [CNT_W-1:0]      acc_count;
    logic                  count_hit;

    logic [SUM_W-1:0]      mul_a;
    logic [MB_W-1:0]       mul_b;
    logic [PROD_W-1:0]     mul_p;

    logic [DEN_W+1:0]      div_t;
    logic [DEN_W+1:0]      div_d;
    logic                  div_ge;
    logic [DEN_W+1:0]      div_r;
    logic [AVG_W-1:0]      avg_sat;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_PERIOD_IDX);

    always_comb begin
        if (paddr[APB_ADDR_W-1:2] == REG_PERIOD_IDX) begin
            prdata = APB_DATA_W'(r_period);
        end else begin
            prdata = '0;
        end
    end

    // accumulate: inverted reading, clamped at zero above full scale
    assign raw_ext   = CW'(i_sample.adc_sample);
    assign inv       = (raw_ext > FULL_C) ? '0 : FW'(FULL_C - raw_ext);
    assign sum_add   = {1'b0, r_sum} + (SUM_W + 1)'(inv);
    assign acc_sum   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign acc_count = r_count + CNT_W'(1);
    assign count_hit = (acc_count >= r_period);

    assign in_fire   = i_sample.valid && in_ready;

    // shared multiplier: full scale * count, then sum * 20000
    assign mul_a = mul_num_sel ? r_sum : SUM_W'(r_count);
    assign mul_b = mul_num_sel ? MB_W'(PCT_X2) : MB_W'(ADC_FULL_SCALE);
    assign mul_p = mul_a * mul_b;

    // restoring divide step by twice the denominator
    assign div_t  = {r_rem, r_num[NUM_W-1]};
    assign div_d  = {1'b0, r_den, 1'b0};
    assign div_ge = (div_t >= div_d);
    assign div_r  = div_ge ? (div_t - div_d) : div_t;

    // clamp at 100 percent
    assign avg_sat = (r_ovf || (r_quot > AVG_MAX)) ? AVG_MAX : r_quot;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && count_hit) begin
                    n_state = ST_MUL_DEN;
                end
            end
            ST_MUL_DEN: n_state = ST_MUL_NUM;
            ST_MUL_NUM: n_state = ST_ADD;
            ST_ADD:     n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready    = 1'b0;
        mul_num_sel = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            ST_IDLE:    in_ready    = 1'b1;
            ST_MUL_NUM: mul_num_sel = 1'b1;
            ST_DONE:    load_out    = !r_out_valid || o_result.ready;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_period    <= PERIOD_RESET;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_period <= pwdata[CNT_W-1:0];
            end
            if (in_fire) begin
                r_sum   <= acc_sum;
                r_count <= acc_count;
            end else if (load_out) begin
                r_sum   <= '0;
                r_count <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_MUL_DEN: r_den <= mul_p[DEN_W-1:0];
            ST_MUL_NUM: r_num <= NUM_W'(mul_p);
            ST_ADD: begin
                r_num  <= r_num + NUM_W'(r_den);
                r_rem  <= '0;
                r_quot <= '0;
                r_ovf  <= 1'b0;
                r_step <= '0;
            end
            ST_DIV: begin
                r_rem  <= div_r[DEN_W:0];
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_quot <= {r_quot[AVG_W-2:0], div_ge};
                r_ovf  <= r_ovf | r_quot[AVG_W-1];
                r_step <= r_step + STEP_W'(1);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
        if (load_out) begin
            r_avg <= avg_sat;
            r_spp <= r_count;
        end
    end

    // result channel
    assign i_sample.ready                   = in_ready;
    assign o_result.valid                   = r_out_valid;
    assign o_result.avg_moisture_hundredths = r_avg;
    assign o_result.samples_in_period       = r_spp;

    // checks
    `ASSERT_IMPL(a_avg_in_range, i_clk, i_rst_n, r_out_valid, r_avg <= AVG_MAX, "average above 100 percent")
    `ASSERT_IMPL(a_spp_nonzero, i_clk, i_rst_n, r_out_valid, r_spp != '0, "empty period reported")
    `ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, r_state == ST_DIV, r_rem < div_d[DEN_W:0], "divider remainder out of range")
    `ASSERT_NEXT(a_clear_after_load, i_clk, i_rst_n, load_out, (r_sum == '0) && (r_count == '0) && r_out_valid, "accumulator not cleared at period end")

endmodule
